/* src/hss_pkg.sv */
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, microcode encodings and program addresses of the incremental
// Halton sequence step core.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int Q_W    = 48;
  localparam int HALF_W = Q_W / 2;
  localparam int PC_W   = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CALC_E,
    OP_MUL_INIT,
    OP_MUL_P0,
    OP_MUL_P1,
    OP_MUL_P2,
    OP_MUL_P3,
    OP_MUL_END,
    OP_NEXT_POW,
    OP_COMBINE,
    OP_SIMPLE,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_CNT_ZERO,
    C_INV_LT_E,
    C_POW_DONE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    pc_t    target;
  } ucode_word_t;

  typedef struct packed {
    logic cnt_zero;
    logic inv_lt_e;
    logic pow_done;
  } dp_stat_t;

  typedef struct packed {
    logic   busy;
    logic   emit;
    dp_op_t op;
  } seq_ctl_t;

  localparam pc_t PC_TEST_CNT = 4'd0;
  localparam pc_t PC_CALC_E   = 4'd1;
  localparam pc_t PC_TEST_INV = 4'd2;
  localparam pc_t PC_MUL_INIT = 4'd3;
  localparam pc_t PC_MUL_P0   = 4'd4;
  localparam pc_t PC_MUL_P1   = 4'd5;
  localparam pc_t PC_MUL_P2   = 4'd6;
  localparam pc_t PC_MUL_P3   = 4'd7;
  localparam pc_t PC_MUL_END  = 4'd8;
  localparam pc_t PC_TEST_H   = 4'd9;
  localparam pc_t PC_NEXT_POW = 4'd10;
  localparam pc_t PC_COMBINE  = 4'd11;
  localparam pc_t PC_SIMPLE   = 4'd12;
  localparam pc_t PC_FINISH   = 4'd13;

  localparam logic [Q_W-1:0] INV_BASE_RESET = 48'h8000_0000_0000;

endpackage

/* src/hss_in_if.sv */
// ----------------------------------------------------------------------------
// hss_in_if
// Request channel: a load or advance command with its operands.
// ----------------------------------------------------------------------------
interface hss_in_if #(
  parameter int COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [47:0]           start_value;
  logic [COUNT_BITS-1:0] step_count;

  modport source (output valid, command, start_value, step_count, input ready);
  modport sink   (input valid, command, start_value, step_count, output ready);
endinterface

/* src/hss_out_if.sv */
// ----------------------------------------------------------------------------
// hss_out_if
// Result channel: the sample produced by an advance request.
// ----------------------------------------------------------------------------
interface hss_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

/* src/halton_sequence_step_core.sv */
// ----------------------------------------------------------------------------
// halton_sequence_step_core
// One-dimensional incremental Halton generator in unsigned Q0.48 fixed point.
// ----------------------------------------------------------------------------
// A load request sets the running offset and returns nothing. An advance
// request returns one sample after all its steps. A step where the reciprocal
// is below the error term adds the reciprocal to the offset; any other step
// forms powers of the reciprocal with the microcode sequencer and its single
// 24x24 multiplier, which builds each product from four partial products. A
// new request is taken once the program has handed its sample to the output
// register.
module halton_sequence_step_core #(
  parameter int FRAC_BITS  = 48,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  hss_in_if.sink                  in_req,
  hss_out_if.source               out_res,
  input  logic                    cfg_we,
  input  logic [hss_pkg::Q_W-1:0] cfg_wdata
);

  logic [hss_pkg::Q_W-1:0] inv_cfg_r;
  logic                    out_valid_r;
  logic [hss_pkg::Q_W-1:0] sample_r;
  logic                    out_busy;
  logic                    accept;
  logic                    load;
  logic                    start;
  logic [hss_pkg::Q_W-1:0] dp_sample;
  hss_pkg::seq_ctl_t       ctl;
  hss_pkg::dp_stat_t       stat;

  assign accept   = in_req.valid && in_req.ready;
  assign load     = accept && !in_req.command;
  assign start    = accept && in_req.command;
  assign out_busy = out_valid_r && !out_res.ready;
  assign in_req.ready  = !ctl.busy;
  assign out_res.valid  = out_valid_r;
  assign out_res.sample = sample_r;

  hss_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_busy (out_busy),
    .stat     (stat),
    .ctl      (ctl)
  );

  hss_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .start       (start),
    .start_value (in_req.start_value),
    .step_count  (in_req.step_count),
    .inv_cfg     (inv_cfg_r),
    .op          (ctl.op),
    .stat        (stat),
    .sample      (dp_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_cfg_r   <= hss_pkg::INV_BASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        inv_cfg_r <= cfg_wdata;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      sample_r <= dp_sample;
    end
  end

`ifndef SYNTHESIS
  a_adv_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ctl.busy) else $error("advance request did not start the program");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !ctl.busy) else $error("load request started the program");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid_r) else $error("emitted sample not held in output");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !out_busy) else $error("sample emitted over a waiting result");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.busy |-> !ctl.emit) else $error("sample emitted while idle");
`endif

endmodule

/* src/hss_ucode_rom.sv */
// ----------------------------------------------------------------------------
// hss_ucode_rom
// Read-only program store holding one control word per sequencer step.
// ----------------------------------------------------------------------------
module hss_ucode_rom (
  input  hss_pkg::pc_t        pc,
  output hss_pkg::ucode_word_t cw
);

  always_comb begin
    unique case (pc)
      hss_pkg::PC_TEST_CNT: cw = '{hss_pkg::OP_NOP,      hss_pkg::C_CNT_ZERO,
                                   hss_pkg::PC_FINISH};
      hss_pkg::PC_CALC_E:   cw = '{hss_pkg::OP_CALC_E,   hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_TEST_INV: cw = '{hss_pkg::OP_NOP,      hss_pkg::C_INV_LT_E,
                                   hss_pkg::PC_SIMPLE};
      hss_pkg::PC_MUL_INIT: cw = '{hss_pkg::OP_MUL_INIT, hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_MUL_P0:   cw = '{hss_pkg::OP_MUL_P0,   hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_MUL_P1:   cw = '{hss_pkg::OP_MUL_P1,   hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_MUL_P2:   cw = '{hss_pkg::OP_MUL_P2,   hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_MUL_P3:   cw = '{hss_pkg::OP_MUL_P3,   hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_MUL_END:  cw = '{hss_pkg::OP_MUL_END,  hss_pkg::C_NEVER,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_TEST_H:   cw = '{hss_pkg::OP_NOP,      hss_pkg::C_POW_DONE,
                                   hss_pkg::PC_COMBINE};
      hss_pkg::PC_NEXT_POW: cw = '{hss_pkg::OP_NEXT_POW, hss_pkg::C_ALWAYS,
                                   hss_pkg::PC_MUL_P0};
      hss_pkg::PC_COMBINE:  cw = '{hss_pkg::OP_COMBINE,  hss_pkg::C_ALWAYS,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_SIMPLE:   cw = '{hss_pkg::OP_SIMPLE,   hss_pkg::C_ALWAYS,
                                   hss_pkg::PC_TEST_CNT};
      hss_pkg::PC_FINISH:   cw = '{hss_pkg::OP_EMIT,     hss_pkg::C_OUT_BUSY,
                                   hss_pkg::PC_FINISH};
      default:              cw = '{hss_pkg::OP_NOP,      hss_pkg::C_ALWAYS,
                                   hss_pkg::PC_FINISH};
    endcase
  end

endmodule

/* src/hss_sequencer.sv */
// ----------------------------------------------------------------------------
// hss_sequencer
// Step counter with conditional jumps that walks the microcode program.
// ----------------------------------------------------------------------------
module hss_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_busy,
  input  hss_pkg::dp_stat_t    stat,
  output hss_pkg::seq_ctl_t    ctl
);

  hss_pkg::pc_t        pc_r;
  hss_pkg::pc_t        pc_nxt;
  logic                busy_r;
  logic                busy_nxt;
  logic                taken;
  logic                emit;
  hss_pkg::ucode_word_t cw;

  hss_ucode_rom u_rom (
    .pc (pc_r),
    .cw (cw)
  );

  always_comb begin
    unique case (cw.cond)
      hss_pkg::C_NEVER:    taken = 1'b0;
      hss_pkg::C_ALWAYS:   taken = 1'b1;
      hss_pkg::C_CNT_ZERO: taken = stat.cnt_zero;
      hss_pkg::C_INV_LT_E: taken = stat.inv_lt_e;
      hss_pkg::C_POW_DONE: taken = stat.pow_done;
      hss_pkg::C_OUT_BUSY: taken = out_busy;
      default:             taken = 1'b0;
    endcase

    emit     = busy_r && (cw.op == hss_pkg::OP_EMIT) && !out_busy;
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = hss_pkg::PC_TEST_CNT;
    end else if (busy_r) begin
      pc_nxt = taken ? cw.target : pc_r + hss_pkg::pc_t'(1);
      if (emit) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= hss_pkg::PC_TEST_CNT;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctl.busy = busy_r;
  assign ctl.emit = emit;
  assign ctl.op   = busy_r ? cw.op : hss_pkg::OP_NOP;

endmodule

/* src/hss_datapath.sv */
// ----------------------------------------------------------------------------
// hss_datapath
// Offset, power and error registers with a shared 24x24 multiplier that
// forms each fixed-point product from four partial products.
// ----------------------------------------------------------------------------
module hss_datapath #(
  parameter int FRAC_BITS  = 48,
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic                      start,
  input  logic [hss_pkg::Q_W-1:0]   start_value,
  input  logic [COUNT_BITS-1:0]     step_count,
  input  logic [hss_pkg::Q_W-1:0]   inv_cfg,
  input  hss_pkg::dp_op_t           op,
  output hss_pkg::dp_stat_t         stat,
  output logic [hss_pkg::Q_W-1:0]   sample
);

  localparam int QW    = hss_pkg::Q_W;
  localparam int HW    = hss_pkg::HALF_W;
  localparam int W     = (FRAC_BITS + 2 > QW) ? FRAC_BITS + 2 : QW + 1;
  localparam int ACC_W = 2 * QW;
  localparam int K_W   = $clog2(FRAC_BITS + 1);
  localparam logic [63:0] EPS64 =
    ((64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] QMAX64 =
    (FRAC_BITS >= QW) ? ((64'd1 << QW) - 64'd1) : ((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [QW-1:0] QMAX = QMAX64[QW-1:0];
  localparam logic [W-1:0]  QEPS = EPS64[W-1:0];
  localparam logic [W-1:0]  QONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [QW-1:0]         off_r, off_nxt;
  logic [QW-1:0]         inv_r, inv_nxt;
  logic [QW-1:0]         a_r, a_nxt;
  logic [QW-1:0]         last_r, last_nxt;
  logic [QW-1:0]         h_r, h_nxt;
  logic [W-1:0]          e_r, e_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  zero_r, zero_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [HW-1:0]         mul_a, mul_b;
  logic [QW-1:0]         prod;
  logic [W-1:0]          d, sum3;

  function automatic logic [QW-1:0] sat_q(input logic [W-1:0] x);
    logic [QW-1:0] r;
    if (x > W'(QMAX)) begin
      r = QMAX;
    end else begin
      r = x[QW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      hss_pkg::OP_MUL_P0: begin mul_a = a_r[HW-1:0];  mul_b = inv_r[HW-1:0];  end
      hss_pkg::OP_MUL_P1: begin mul_a = a_r[HW-1:0];  mul_b = inv_r[QW-1:HW]; end
      hss_pkg::OP_MUL_P2: begin mul_a = a_r[QW-1:HW]; mul_b = inv_r[HW-1:0];  end
      hss_pkg::OP_MUL_P3: begin mul_a = a_r[QW-1:HW]; mul_b = inv_r[QW-1:HW]; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    off_nxt  = off_r;
    inv_nxt  = inv_r;
    a_nxt    = a_r;
    last_nxt = last_r;
    h_nxt    = h_r;
    e_nxt    = e_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    acc_nxt  = acc_r;
    d        = QONE - W'(off_r);
    sum3     = W'(off_r) + W'(last_r) + W'(h_r);

    if (load) begin
      off_nxt = sat_q(W'(start_value));
    end else if (start) begin
      inv_nxt  = sat_q(W'(inv_cfg));
      cnt_nxt  = step_count;
      zero_nxt = (step_count == '0);
    end else begin
      unique case (op)
        hss_pkg::OP_CALC_E: begin
          e_nxt   = (d >= QEPS) ? d - QEPS : QEPS - d;
          cnt_nxt = cnt_r - COUNT_BITS'(1);
        end
        hss_pkg::OP_MUL_INIT: begin
          a_nxt    = inv_r;
          last_nxt = inv_r;
          k_nxt    = K_W'(1);
        end
        hss_pkg::OP_MUL_P0: acc_nxt = ACC_W'(prod);
        hss_pkg::OP_MUL_P1: acc_nxt = acc_r + (ACC_W'(prod) << HW);
        hss_pkg::OP_MUL_P2: acc_nxt = acc_r + (ACC_W'(prod) << HW);
        hss_pkg::OP_MUL_P3: acc_nxt = acc_r + (ACC_W'(prod) << QW);
        hss_pkg::OP_MUL_END: h_nxt = QW'(acc_r >> FRAC_BITS);
        hss_pkg::OP_NEXT_POW: begin
          a_nxt    = h_r;
          last_nxt = h_r;
          k_nxt    = k_r + K_W'(1);
        end
        hss_pkg::OP_COMBINE: off_nxt = (sum3 >= QONE) ? sat_q(sum3 - QONE) : '0;
        hss_pkg::OP_SIMPLE:  off_nxt = sat_q(W'(off_r) + W'(inv_r));
        default: begin
          off_nxt = off_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else begin
      off_r <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inv_r  <= inv_nxt;
    a_r    <= a_nxt;
    last_r <= last_nxt;
    h_r    <= h_nxt;
    e_r    <= e_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
    acc_r  <= acc_nxt;
  end

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.inv_lt_e = (W'(inv_r) < e_r);
  assign stat.pow_done = !((W'(h_r) >= e_r) && (h_r != '0) && (k_r < K_W'(FRAC_BITS)));
  assign sample        = zero_r ? '0 : off_r;

endmodule
